// ----- rtl/tcge_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcge_pkg: shared types, constants and font for the text glyph emitter
// Holds the byte codes, the control and status structs between sequencer
// and datapath, and the fixed 5x7 font table.
// ----------------------------------------------------------------------------
package tcge_pkg;

  localparam int WRAP_COLUMN_DEF = 15;
  localparam int CELL_WIDTH_DEF  = 6;
  localparam int GLYPH_COLS      = 5;

  localparam int CODE_W  = 8;
  localparam int COL_W   = 4;
  localparam int ROW_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int GIDX_W  = 7;
  localparam int GLYPH_W = GLYPH_COLS * BYTE_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_CHARSET = 1'd1;

  localparam logic CMD_PUT    = 1'b0;
  localparam logic CMD_SETPOS = 1'b1;

  localparam logic [CODE_W-1:0] CODE_BS      = 8'd8;
  localparam logic [CODE_W-1:0] CODE_LF      = 8'd10;
  localparam logic [CODE_W-1:0] CODE_CR      = 8'd13;
  localparam logic [CODE_W-1:0] CODE_FIRST   = 8'h20;
  localparam logic [CODE_W-1:0] LIMIT_FULL   = 8'd126;
  localparam logic [CODE_W-1:0] LIMIT_BASIC  = 8'd95;
  localparam logic [CODE_W-1:0] CODE_SUBST   = 8'd92;

  localparam logic [BYTE_W-1:0] POS_COL_BASE = 8'h80;
  localparam logic [BYTE_W-1:0] POS_ROW_BASE = 8'h40;
  localparam logic [BYTE_W-1:0] FILL_INVERSE = 8'hff;
  localparam logic [BYTE_W-1:0] FILL_NORMAL  = 8'h00;

  typedef enum logic [1:0] {
    SEL_POS_COL,
    SEL_POS_ROW,
    SEL_GLYPH,
    SEL_FILL
  } sel_t;

  typedef struct packed {
    logic accept;
    logic emit;
    sel_t sel;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic is_setpos;
    logic is_cr;
    logic is_lf;
    logic is_bs;
    logic col_zero;
    logic out_free;
  } status_t;

  // Column 0 of a glyph sits in the low byte.
  function automatic logic [GLYPH_W-1:0] font_glyph(input logic [GIDX_W-1:0] idx);
    logic [GLYPH_W-1:0] g;
    case (idx)
      7'd0:  g = 40'h0000000000;
      7'd1:  g = 40'h00002f0000;
      7'd2:  g = 40'h0007000700;
      7'd3:  g = 40'h147f147f14;
      7'd4:  g = 40'h122a7f2a24;
      7'd5:  g = 40'h462610c8c4;
      7'd6:  g = 40'h5022554936;
      7'd7:  g = 40'h0000030500;
      7'd8:  g = 40'h0041221c00;
      7'd9:  g = 40'h001c224100;
      7'd10: g = 40'h14083e0814;
      7'd11: g = 40'h08083e0808;
      7'd12: g = 40'h0030500000;
      7'd13: g = 40'h1010101010;
      7'd14: g = 40'h0000606000;
      7'd15: g = 40'h0204081020;
      7'd16: g = 40'h3e4549513e;
      7'd17: g = 40'h00407f4200;
      7'd18: g = 40'h4649516142;
      7'd19: g = 40'h314b454121;
      7'd20: g = 40'h107f121418;
      7'd21: g = 40'h3945454527;
      7'd22: g = 40'h3049494a3c;
      7'd23: g = 40'h0305097101;
      7'd24: g = 40'h3649494936;
      7'd25: g = 40'h1e29494906;
      7'd26: g = 40'h0000363600;
      7'd27: g = 40'h0000365600;
      7'd28: g = 40'h0041221408;
      7'd29: g = 40'h1414141414;
      7'd30: g = 40'h0814224100;
      7'd31: g = 40'h0609510102;
      7'd32: g = 40'h3e51594932;
      7'd33: g = 40'h7e1111117e;
      7'd34: g = 40'h364949497f;
      7'd35: g = 40'h224141413e;
      7'd36: g = 40'h1c2241417f;
      7'd37: g = 40'h414949497f;
      7'd38: g = 40'h010909097f;
      7'd39: g = 40'h7a4949413e;
      7'd40: g = 40'h7f0808087f;
      7'd41: g = 40'h00417f4100;
      7'd42: g = 40'h013f414020;
      7'd43: g = 40'h412214087f;
      7'd44: g = 40'h404040407f;
      7'd45: g = 40'h7f020c027f;
      7'd46: g = 40'h7f1008047f;
      7'd47: g = 40'h3e4141413e;
      7'd48: g = 40'h060909097f;
      7'd49: g = 40'h5e2151413e;
      7'd50: g = 40'h462919097f;
      7'd51: g = 40'h3149494946;
      7'd52: g = 40'h01017f0101;
      7'd53: g = 40'h3f4040403f;
      7'd54: g = 40'h1f2040201f;
      7'd55: g = 40'h3f4038403f;
      7'd56: g = 40'h6314081463;
      7'd57: g = 40'h0708700807;
      7'd58: g = 40'h4345495161;
      7'd59: g = 40'h0041417f00;
      7'd60: g = 40'h552a552a55;
      7'd61: g = 40'h007f414100;
      7'd62: g = 40'h0402010204;
      7'd63: g = 40'h4040404040;
      7'd64: g = 40'h0004020100;
      7'd65: g = 40'h7854545420;
      7'd66: g = 40'h384444487f;
      7'd67: g = 40'h2044444438;
      7'd68: g = 40'h7f48444438;
      7'd69: g = 40'h1854545438;
      7'd70: g = 40'h0201097e08;
      7'd71: g = 40'h3e5252520c;
      7'd72: g = 40'h780404087f;
      7'd73: g = 40'h00407d4400;
      7'd74: g = 40'h003d444020;
      7'd75: g = 40'h004428107f;
      7'd76: g = 40'h00407f4100;
      7'd77: g = 40'h780418047c;
      7'd78: g = 40'h780404087c;
      7'd79: g = 40'h3844444438;
      7'd80: g = 40'h081414147c;
      7'd81: g = 40'h7c18141408;
      7'd82: g = 40'h080404087c;
      7'd83: g = 40'h2054545448;
      7'd84: g = 40'h2040443f04;
      7'd85: g = 40'h7c2040403c;
      7'd86: g = 40'h1c2040201c;
      7'd87: g = 40'h3c4030403c;
      7'd88: g = 40'h4428102844;
      7'd89: g = 40'h3c5050500c;
      7'd90: g = 40'h444c546444;
      7'd91: g = 40'h003e7f7f3e;
      7'd92: g = 40'h0006090906;
      7'd93: g = 40'h0101010101;
      7'd94: g = 40'h0017151d00;
      default: g = 40'h0000000000;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tcge_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcge_if: channel interfaces of the text glyph emitter
// Input request channel, display byte channel and configuration write
// channel, each with valid, ready and its payload.
// ----------------------------------------------------------------------------
interface tcge_in_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic [tcge_pkg::CODE_W-1:0]    char_code;
  logic [tcge_pkg::COL_W-1:0]     target_col;
  logic [tcge_pkg::ROW_W-1:0]     target_row;
  modport source (output valid, cmd, char_code, target_col, target_row, input ready);
  modport sink   (input valid, cmd, char_code, target_col, target_row, output ready);
endinterface

interface tcge_out_if;
  logic                           valid;
  logic                           ready;
  logic                           is_data;
  logic [tcge_pkg::BYTE_W-1:0]    out_byte;
  logic                           last;
  modport source (output valid, is_data, out_byte, last, input ready);
  modport sink   (input valid, is_data, out_byte, last, output ready);
endinterface

interface tcge_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tcge_pkg::CFG_IDX_W-1:0]  index;
  logic [tcge_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/tcge_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcge_ctrl: byte sequencer of the text glyph emitter
// Accepts one request at a time and steps through position, glyph and fill
// beats, issuing one emit command per free output slot.
// ----------------------------------------------------------------------------
module tcge_ctrl #(
  parameter int CELL_WIDTH = tcge_pkg::CELL_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tcge_pkg::status_t st,
  output tcge_pkg::cmd_t         cmd
);

  localparam int CNT_W = $clog2(CELL_WIDTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GLYPH,
    S_FILL,
    S_POS_COL,
    S_POS_ROW
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             final_r, final_nxt;
  logic             accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    final_nxt  = final_r;
    cmd.accept = accept;
    cmd.emit   = 1'b0;
    cmd.sel    = tcge_pkg::SEL_POS_COL;
    cmd.last   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (st.is_setpos || st.is_cr || st.is_lf) begin
            state_nxt = S_POS_COL;
            final_nxt = 1'b1;
          end else if (st.is_bs) begin
            if (!st.col_zero) begin
              state_nxt = S_POS_COL;
              final_nxt = 1'b0;
            end
          end else begin
            state_nxt = S_GLYPH;
            cnt_nxt   = CNT_W'(tcge_pkg::GLYPH_COLS - 1);
            final_nxt = 1'b1;
          end
        end
      end
      S_GLYPH: begin
        cmd.sel = tcge_pkg::SEL_GLYPH;
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (cnt_r == '0) begin
            state_nxt = S_FILL;
            cnt_nxt   = CNT_W'(CELL_WIDTH - tcge_pkg::GLYPH_COLS - 1);
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
      end
      S_FILL: begin
        cmd.sel = tcge_pkg::SEL_FILL;
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (cnt_r == '0) begin
            state_nxt = S_POS_COL;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
      end
      S_POS_COL: begin
        cmd.sel = tcge_pkg::SEL_POS_COL;
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_POS_ROW;
        end
      end
      S_POS_ROW: begin
        cmd.sel  = tcge_pkg::SEL_POS_ROW;
        cmd.last = final_r;
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (final_r) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_FILL;
            cnt_nxt   = CNT_W'(CELL_WIDTH - 1);
            final_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      final_r <= final_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tcge_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcge_datapath: cursor, glyph and output registers of the text glyph emitter
// Decodes requests, updates the cursor on accept, loads the glyph from the
// font table and drives the registered display byte channel.
// ----------------------------------------------------------------------------
module tcge_datapath #(
  parameter int WRAP_COLUMN = tcge_pkg::WRAP_COLUMN_DEF,
  parameter int CELL_WIDTH  = tcge_pkg::CELL_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_cmd,
  input  wire logic [tcge_pkg::CODE_W-1:0]     in_char_code,
  input  wire logic [tcge_pkg::COL_W-1:0]      in_target_col,
  input  wire logic [tcge_pkg::ROW_W-1:0]      in_target_row,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tcge_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tcge_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_is_data,
  output logic [tcge_pkg::BYTE_W-1:0]          out_byte,
  output logic                                 out_last,
  input  wire tcge_pkg::cmd_t                  cmd,
  output tcge_pkg::status_t                    st
);

  localparam int COL_W = tcge_pkg::COL_W;
  localparam int ROW_W = tcge_pkg::ROW_W;
  localparam int BW    = tcge_pkg::BYTE_W;

  logic [COL_W-1:0]              col_r, col_nxt;
  logic [ROW_W-1:0]              row_r, row_nxt;
  logic                          inverse_r, full_r;
  logic [tcge_pkg::GLYPH_W-1:0]  glyph_r;
  logic                          out_valid_r;
  logic                          is_data_r, last_r;
  logic [BW-1:0]                 byte_r;
  logic [BW-1:0]                 byte_nxt;
  logic [BW-1:0]                 fill;
  logic [tcge_pkg::CODE_W-1:0]   limit;
  logic [tcge_pkg::CODE_W-1:0]   code_eff;
  logic [tcge_pkg::GIDX_W-1:0]   gidx;
  logic [COL_W:0]                col_inc;
  logic                          ctl_code;

  assign st.is_setpos = (in_cmd == tcge_pkg::CMD_SETPOS);
  assign st.is_cr     = !st.is_setpos && (in_char_code == tcge_pkg::CODE_CR);
  assign st.is_lf     = !st.is_setpos && (in_char_code == tcge_pkg::CODE_LF);
  assign st.is_bs     = !st.is_setpos && (in_char_code == tcge_pkg::CODE_BS);
  assign st.col_zero  = (col_r == '0);
  assign st.out_free  = !out_valid_r || out_ready;
  assign ctl_code     = st.is_setpos || st.is_cr || st.is_lf || st.is_bs;

  assign limit    = full_r ? tcge_pkg::LIMIT_FULL : tcge_pkg::LIMIT_BASIC;
  assign code_eff = (in_char_code < tcge_pkg::CODE_FIRST || in_char_code > limit) ?
                    tcge_pkg::CODE_SUBST : in_char_code;
  assign gidx     = tcge_pkg::GIDX_W'(code_eff - tcge_pkg::CODE_FIRST);
  assign col_inc  = {1'b0, col_r} + 1'b1;
  assign fill     = inverse_r ? tcge_pkg::FILL_INVERSE : tcge_pkg::FILL_NORMAL;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (st.is_setpos) begin
      col_nxt = in_target_col;
      row_nxt = in_target_row;
    end else if (st.is_cr) begin
      col_nxt = '0;
    end else if (st.is_lf) begin
      row_nxt = row_r + 1'b1;
    end else if (st.is_bs) begin
      if (!st.col_zero) begin
        col_nxt = col_r - 1'b1;
      end
    end else if (col_inc > (COL_W + 1)'(WRAP_COLUMN)) begin
      col_nxt = '0;
      row_nxt = row_r + 1'b1;
    end else begin
      col_nxt = col_inc[COL_W-1:0];
    end
  end

  always_comb begin
    unique case (cmd.sel)
      tcge_pkg::SEL_POS_COL: byte_nxt = tcge_pkg::POS_COL_BASE +
                                        BW'({{(BW - COL_W){1'b0}}, col_r} * BW'(CELL_WIDTH));
      tcge_pkg::SEL_POS_ROW: byte_nxt = tcge_pkg::POS_ROW_BASE + row_r;
      tcge_pkg::SEL_GLYPH:   byte_nxt = glyph_r[BW-1:0];
      tcge_pkg::SEL_FILL:    byte_nxt = fill;
      default:               byte_nxt = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      inverse_r   <= 1'b0;
      full_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          tcge_pkg::CFG_INVERSE_MODE: inverse_r <= cfg_data[0];
          tcge_pkg::CFG_FULL_CHARSET: full_r    <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !ctl_code) begin
      glyph_r <= tcge_pkg::font_glyph(gidx) ^ {tcge_pkg::GLYPH_COLS{fill}};
    end else if (cmd.emit && cmd.sel == tcge_pkg::SEL_GLYPH) begin
      glyph_r <= glyph_r >> BW;
    end
    if (cmd.emit) begin
      byte_r    <= byte_nxt;
      is_data_r <= (cmd.sel == tcge_pkg::SEL_GLYPH) || (cmd.sel == tcge_pkg::SEL_FILL);
      last_r    <= cmd.last;
    end
  end

  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_is_data = is_data_r;
  assign out_byte    = byte_r;
  assign out_last    = last_r;

endmodule

`default_nettype wire

// ----- rtl/text_cursor_glyph_emitter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_cursor_glyph_emitter: character to display byte controller
// Keeps a text cursor and turns characters and position requests into
// tagged command and data bytes for a column-addressed display.
// ----------------------------------------------------------------------------
// Channel   Dir   Payload                                   Beat when
// in_ch     in    cmd, char_code, target_col, target_row    valid && ready
// out_ch    out   is_data, out_byte, last                   valid && ready
// cfg_ch    in    index, data                               valid && ready
//
// After its accept, a request emits glyph columns, fill, then column and row
// for a printable character; column and row for set position, carriage return
// or line feed; position, a cell of fill and position for a backspace; nothing
// for a backspace at column 0. The single output register moves one beat per
// cycle unless stalled. Reset clears the cursor and inverse mode, selects the
// full character set; no clearing pass is needed. A stalled output holds the
// sequencer; the next request is taken while the final byte still waits.
// ----------------------------------------------------------------------------
module text_cursor_glyph_emitter #(
  parameter int WRAP_COLUMN = tcge_pkg::WRAP_COLUMN_DEF,
  parameter int CELL_WIDTH  = tcge_pkg::CELL_WIDTH_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  tcge_in_if.sink     in_ch,
  tcge_out_if.source  out_ch,
  tcge_cfg_if.sink    cfg_ch
);

  tcge_pkg::cmd_t    cmd;
  tcge_pkg::status_t st;

  tcge_ctrl #(
    .CELL_WIDTH (CELL_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  tcge_datapath #(
    .WRAP_COLUMN (WRAP_COLUMN),
    .CELL_WIDTH  (CELL_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_cmd        (in_ch.cmd),
    .in_char_code  (in_ch.char_code),
    .in_target_col (in_ch.target_col),
    .in_target_row (in_ch.target_row),
    .cfg_valid     (cfg_ch.valid),
    .cfg_ready     (cfg_ch.ready),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_is_data   (out_ch.is_data),
    .out_byte      (out_ch.out_byte),
    .out_last      (out_ch.last),
    .cmd           (cmd),
    .st            (st)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !(st.is_bs && st.col_zero)) |=> !in_ch.ready)
    else $error("request accepted without starting its byte sequence");

  a_idle_pending_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.ready && out_ch.valid) |-> out_ch.last)
    else $error("sequencer idle while a non-final byte is pending");

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.out_free)
    else $error("byte emitted into an occupied output register");

  a_no_emit_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !cmd.emit)
    else $error("emit issued in the accept cycle");

endmodule

`default_nettype wire
